// ----- rtl/http_chunked_body_decoder_defines.svh -----
// assertion macros for the chunked body decoder
// no dependencies; taken in by hcbd_back, the module that carries assertions
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define HCBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hcbd same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hcbd next-cycle check failed");

`endif

// ----- rtl/hcbd_pkg.sv -----
// shared types and constants of the chunked body decoder
// no dependencies
package hcbd_pkg;

    localparam int TOTAL_BITS  = 32;
    localparam int HEX_BITS    = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        PH_SKIP = 3'd0,
        PH_SIZE = 3'd1,
        PH_DATA = 3'd2,
        PH_DONE = 3'd3
    } t_phase;

    // one classified input item
    typedef struct packed {
        logic [7:0]          byte_val;
        logic                start;
        logic                is_cr;
        logic                is_lf;
        logic                is_nul;
        logic                is_hex;
        logic [HEX_BITS-1:0] hex_val;
    } t_cls;

endpackage

// ----- rtl/hcbd_front.sv -----
// front part: classifies each raw body byte for the back part
// depends on hcbd_pkg
module hcbd_front (
    input  logic [7:0]    i_body_byte,
    input  logic          i_start_of_body,
    output hcbd_pkg::t_cls o_cls
);
    import hcbd_pkg::*;

    always_comb begin
        o_cls.byte_val = i_body_byte;
        o_cls.start    = i_start_of_body;
        o_cls.is_cr    = (i_body_byte == CHAR_CR);
        o_cls.is_lf    = (i_body_byte == CHAR_LF);
        o_cls.is_nul   = (i_body_byte == CHAR_NUL);
        o_cls.is_hex   = 1'b0;
        o_cls.hex_val  = '0;
        case (i_body_byte) inside
            [8'h30:8'h39]: begin
                o_cls.is_hex  = 1'b1;
                o_cls.hex_val = i_body_byte[3:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]: begin
                // low nibble 1..6 maps to 10..15
                o_cls.is_hex  = 1'b1;
                o_cls.hex_val = 4'(i_body_byte[3:0] + 4'd9);
            end
            default: begin
                o_cls.is_hex = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/hcbd_queue.sv -----
// short queue of classified items between front and back
// depends on hcbd_pkg
module hcbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hcbd_pkg::t_cls i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hcbd_pkg::t_cls o_data
);
    import hcbd_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    t_cls                r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? PTR_BITS'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = do_pop ? PTR_BITS'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = CNT_BITS'(r_count + 1'b1);
        end else if (do_pop && !do_push) begin
            n_count = CNT_BITS'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/hcbd_back.sv -----
// back part: chunk state machine and output register
// depends on hcbd_pkg and http_chunked_body_decoder_defines.svh
module hcbd_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  hcbd_pkg::t_cls                  i_q_data,
    output logic                            o_q_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_result_kind,
    output logic [7:0]                      o_payload_byte,
    output logic [hcbd_pkg::TOTAL_BITS-1:0] o_total_bytes,
    output logic                            o_size_overflow
);
    import hcbd_pkg::*;
    `include "http_chunked_body_decoder_defines.svh"

    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_acc, n_acc;
    logic                  r_hex_ended, n_hex_ended;
    logic [COUNT_BITS-1:0] r_left, n_left;
    logic [TOTAL_BITS-1:0] r_count, n_count;
    logic                  r_ovf, n_ovf;

    logic                  r_out_valid, n_out_valid;
    logic                  r_kind, n_kind;
    logic [7:0]            r_byte, n_byte;
    logic [TOTAL_BITS-1:0] r_total, n_total;
    logic                  r_ovf_out, n_ovf_out;

    // state as seen by the current item, after a restart
    t_phase                e_phase;
    logic [COUNT_BITS-1:0] e_acc;
    logic                  e_hex_ended;
    logic [COUNT_BITS-1:0] e_left;
    logic [TOTAL_BITS-1:0] e_count;
    logic                  e_ovf;

    logic                  emit;
    logic                  emit_kind;
    logic                  in_size;
    logic [COUNT_BITS-1:0] left_dec;

    assign o_q_pop = i_q_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        e_phase     = i_q_data.start ? PH_SKIP : r_phase;
        e_acc       = i_q_data.start ? '0 : r_acc;
        e_hex_ended = i_q_data.start ? 1'b0 : r_hex_ended;
        e_left      = i_q_data.start ? '0 : r_left;
        e_count     = i_q_data.start ? '0 : r_count;
        e_ovf       = i_q_data.start ? 1'b0 : r_ovf;

        n_phase     = e_phase;
        n_acc       = e_acc;
        n_hex_ended = e_hex_ended;
        n_left      = e_left;
        n_count     = e_count;
        n_ovf       = e_ovf;
        emit        = 1'b0;
        emit_kind   = KIND_END;
        in_size     = 1'b0;
        left_dec    = (e_left != '0) ? COUNT_BITS'(e_left - 1'b1) : '0;

        case (e_phase)
            PH_SKIP: begin
                if (i_q_data.is_cr || i_q_data.is_lf) begin
                    n_phase = PH_SKIP;
                end else if (i_q_data.is_nul) begin
                    n_phase   = PH_DONE;
                    emit      = 1'b1;
                    emit_kind = KIND_END;
                end else begin
                    // first byte of a size line: fresh line state
                    e_acc       = '0;
                    e_hex_ended = 1'b0;
                    n_acc       = '0;
                    n_hex_ended = 1'b0;
                    n_phase     = PH_SIZE;
                    in_size     = 1'b1;
                end
            end
            PH_SIZE: begin
                in_size = 1'b1;
            end
            PH_DATA: begin
                if (e_count != '1) begin
                    n_count = TOTAL_BITS'(e_count + 1'b1);
                end
                n_left = left_dec;
                if (left_dec == '0) begin
                    n_phase = PH_SKIP;
                end
                emit      = 1'b1;
                emit_kind = KIND_DATA;
            end
            default: begin
                n_phase = e_phase;
            end
        endcase

        if (in_size) begin
            if (i_q_data.is_lf) begin
                if (e_acc == '0) begin
                    n_phase   = PH_DONE;
                    emit      = 1'b1;
                    emit_kind = KIND_END;
                end else begin
                    n_left      = e_acc;
                    n_acc       = '0;
                    n_hex_ended = 1'b0;
                    n_phase     = PH_DATA;
                end
            end else if (!e_hex_ended) begin
                if (!i_q_data.is_hex) begin
                    n_hex_ended = 1'b1;
                end else if (e_acc[COUNT_BITS-1 -: HEX_BITS] != '0) begin
                    // next digit would not fit: saturate
                    n_acc = '1;
                    n_ovf = 1'b1;
                end else begin
                    n_acc = {e_acc[COUNT_BITS-HEX_BITS-1:0], i_q_data.hex_val};
                end
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_byte      = r_byte;
        n_total     = r_total;
        n_ovf_out   = r_ovf_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_q_pop && emit) begin
            n_out_valid = 1'b1;
            n_kind      = emit_kind;
            n_byte      = (emit_kind == KIND_DATA) ? i_q_data.byte_val : 8'h00;
            n_total     = n_count;
            n_ovf_out   = n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_acc       <= '0;
            r_hex_ended <= 1'b0;
            r_left      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_hex_ended <= n_hex_ended;
                r_left      <= n_left;
                r_count     <= n_count;
                r_ovf       <= n_ovf;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_byte    <= n_byte;
        r_total   <= n_total;
        r_ovf_out <= n_ovf_out;
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_payload_byte  = r_byte;
    assign o_total_bytes   = r_total;
    assign o_size_overflow = r_ovf_out;

    `HCBD_ASSERT_NOW(a_data_left_nonzero, i_clk, i_rst_n, r_phase == PH_DATA, r_left != '0)
    `HCBD_ASSERT_NOW(a_end_byte_zero, i_clk, i_rst_n, r_out_valid && r_kind == KIND_END, r_byte == 8'h00)
    `HCBD_ASSERT_NOW(a_data_counted, i_clk, i_rst_n, r_out_valid && r_kind == KIND_DATA, r_total != '0)
    `HCBD_ASSERT_NEXT(a_stall_no_pop, i_clk, i_rst_n, r_out_valid && !i_out_ready, !$past(o_q_pop))

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// HTTP/1.1 chunked body decoder, one raw byte in, at most one result out.
// Input channel: i_in_valid / o_in_ready with i_body_byte and i_start_of_body;
// a byte with i_start_of_body high restarts decoding at a new body.
// Output channel: o_out_valid / i_out_ready with o_result_kind (0 payload byte,
// 1 end of body), o_payload_byte, o_total_bytes and o_size_overflow.
// Size lines take hex digits up to the first other character, end at LF
// (CRLF or bare LF); a zero size or a NUL at a line start ends the body.
// Throughput: one byte per cycle while the output register is empty or the
// receiver takes its result, set by the state update in the back part. A byte
// enters the two-entry queue at the edge that takes it; the state update then
// pops it and loads any result into the output register. Bytes that give no
// result still pass through the queue.
// Reset (i_rst_n low, synchronous) empties the queue and output register and
// readies the decoder for a new body. When the receiver holds i_out_ready low
// the result stays in the output register, the back part stops popping, and
// o_in_ready drops once the queue holds two bytes.
// depends on hcbd_pkg, hcbd_front, hcbd_queue, hcbd_back
module http_chunked_body_decoder #(
    parameter int COUNT_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_body_byte,
    input  logic                            i_start_of_body,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_result_kind,
    output logic [7:0]                      o_payload_byte,
    output logic [hcbd_pkg::TOTAL_BITS-1:0] o_total_bytes,
    output logic                            o_size_overflow
);
    import hcbd_pkg::*;

    t_cls front_cls;
    t_cls q_data;
    logic q_full;
    logic q_valid;
    logic q_pop;

    assign o_in_ready = !q_full;

    hcbd_front u_front (
        .i_body_byte     (i_body_byte),
        .i_start_of_body (i_start_of_body),
        .o_cls           (front_cls)
    );

    hcbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    hcbd_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_payload_byte  (o_payload_byte),
        .o_total_bytes   (o_total_bytes),
        .o_size_overflow (o_size_overflow)
    );

endmodule

// ----- dv/tb.sv -----
// testbench for http_chunked_body_decoder: directed and random chunked bodies,
// checked item by item against a behavioral decoder kept inside the testbench
// depends on hcbd_pkg and the rtl of the decoder
module tb;
    import hcbd_pkg::*;

    localparam int SIZE_BITS   = 32;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [31:0] total;
        logic        ovf;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_body_byte = 8'h00;
    logic                  i_start_of_body = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_result_kind;
    logic [7:0]            o_payload_byte;
    logic [TOTAL_BITS-1:0] o_total_bytes;
    logic                  o_size_overflow;

    // decoder state as seen by the predictor
    t_phase                dec_phase;
    logic [SIZE_BITS-1:0]  dec_size;
    logic [SIZE_BITS-1:0]  dec_left;
    logic                  dec_hex_done;
    logic [31:0]           dec_count;
    logic                  dec_ovf;

    t_result    pending_results[$];
    logic [7:0] body_bytes[$];
    int         items_sent = 0;
    int         failures = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         rx_hold_left = 0;

    http_chunked_body_decoder #(.COUNT_BITS(SIZE_BITS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_body_byte     (i_body_byte),
        .i_start_of_body (i_start_of_body),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_payload_byte  (o_payload_byte),
        .o_total_bytes   (o_total_bytes),
        .o_size_overflow (o_size_overflow)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_out_ready  <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic void reset_decoder();
        dec_phase    = PH_SKIP;
        dec_size     = '0;
        dec_left     = '0;
        dec_hex_done = 1'b0;
        dec_count    = '0;
        dec_ovf      = 1'b0;
    endfunction

    // advances the decoder by one byte; returns 1 when the byte yields a result
    function automatic bit decode_byte(input logic [7:0] b, input logic sob,
                                       output t_result r);
        bit         emit;
        bit         is_hex;
        logic [3:0] nib;
        emit   = 1'b0;
        r      = '0;
        is_hex = 1'b1;
        nib    = '0;
        if (b >= "0" && b <= "9") begin
            nib = 4'(b - "0");
        end else if (b >= "a" && b <= "f") begin
            nib = 4'(b - "a" + 8'd10);
        end else if (b >= "A" && b <= "F") begin
            nib = 4'(b - "A" + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
        if (sob) begin
            reset_decoder();
        end
        // first byte of a line that is not a line break opens the size line
        if (dec_phase == PH_SKIP && b != CHAR_CR && b != CHAR_LF) begin
            if (b == CHAR_NUL) begin
                dec_phase = PH_DONE;
                emit      = 1'b1;
                r.kind    = KIND_END;
            end else begin
                dec_size     = '0;
                dec_hex_done = 1'b0;
                dec_phase    = PH_SIZE;
            end
        end
        case (dec_phase)
            PH_SIZE: begin
                if (b == CHAR_LF) begin
                    if (dec_size == '0) begin
                        dec_phase = PH_DONE;
                        emit      = 1'b1;
                        r.kind    = KIND_END;
                    end else begin
                        dec_left     = dec_size;
                        dec_size     = '0;
                        dec_hex_done = 1'b0;
                        dec_phase    = PH_DATA;
                    end
                end else if (!dec_hex_done) begin
                    if (!is_hex) begin
                        dec_hex_done = 1'b1;
                    end else if (dec_size > ({SIZE_BITS{1'b1}} >> 4)) begin
                        dec_size = '1;
                        dec_ovf  = 1'b1;
                    end else begin
                        dec_size = {dec_size[SIZE_BITS-5:0], nib};
                    end
                end
            end
            PH_DATA: begin
                if (dec_count != '1) begin
                    dec_count = dec_count + 1;
                end
                if (dec_left != '0) begin
                    dec_left = dec_left - 1;
                end
                if (dec_left == '0) begin
                    dec_phase = PH_SKIP;
                end
                emit   = 1'b1;
                r.kind = KIND_DATA;
                r.data = b;
            end
            default: ;
        endcase
        r.total = dec_count;
        r.ovf   = dec_ovf;
        return emit;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: kind %0d byte %0h",
                       o_result_kind, o_payload_byte);
                failures++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(o_result_kind));
                check_field("payload_byte", 32'(want.data), 32'(o_payload_byte));
                check_field("total_bytes", want.total, o_total_bytes);
                check_field("size_overflow", 32'(want.ovf), 32'(o_size_overflow));
            end
        end
    end

    // entered just after a rising edge, returns at the edge that takes the item
    task automatic send_item(input logic [7:0] b, input logic sob);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_body_byte     <= b;
        i_start_of_body <= sob;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (decode_byte(b, sob, r)) begin
            pending_results.push_back(r);
        end
    endtask

    task automatic send_text(input string s, input logic sob_first);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], sob_first && i == 0);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic push_line_break();
        if ($urandom_range(1)) begin
            body_bytes.push_back(CHAR_CR);
        end
        body_bytes.push_back(CHAR_LF);
    endtask

    task automatic push_size_line(input logic [31:0] size);
        int         n_digits;
        logic [3:0] nib;
        logic [7:0] c;
        n_digits = 1;
        while (n_digits < 8 && (size >> (4 * n_digits)) != 0) begin
            n_digits++;
        end
        repeat ($urandom_range(2)) body_bytes.push_back("0");
        for (int i = n_digits - 1; i >= 0; i--) begin
            nib = size[4*i +: 4];
            if (nib < 10) begin
                body_bytes.push_back("0" + nib);
            end else begin
                body_bytes.push_back(($urandom_range(1) ? "A" : "a") + nib - 4'd10);
            end
        end
        // chunk extension: any bytes but LF
        if ($urandom_range(3) == 0) begin
            body_bytes.push_back(";");
            repeat ($urandom_range(4)) begin
                c = 8'($urandom_range(255));
                body_bytes.push_back((c == CHAR_LF) ? " " : c);
            end
        end
        push_line_break();
    endtask

    // one body of 1 to 3 chunks, cut short at a random byte when broken
    task automatic send_random_body(input bit broken);
        int          n_chunks;
        int          cut;
        logic [31:0] size;
        body_bytes.delete();
        n_chunks = $urandom_range(3, 1);
        for (int k = 0; k < n_chunks; k++) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(6, 1);
            push_size_line(size);
            repeat (size) body_bytes.push_back(8'($urandom_range(255)));
            // next size line may also follow the data directly
            if ($urandom_range(3) != 0) begin
                push_line_break();
            end
        end
        if ($urandom_range(7) == 0) begin
            body_bytes.push_back(CHAR_NUL);
        end else begin
            push_size_line(0);
            if ($urandom_range(1)) begin
                push_line_break();
            end
        end
        cut = broken ? $urandom_range(body_bytes.size() - 1, 1) : body_bytes.size();
        for (int i = 0; i < cut; i++) begin
            send_item(body_bytes[i], i == 0);
        end
    endtask

    // right after reset, no start flag: crlf size line, then a line with no digits
    task automatic test_crlf_chunk();
        send_text("2", 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_text("G\n", 1'b0);
    endtask

    // bare lf after an extension, then a 0x prefix that reads as zero
    task automatic test_extension_and_prefix();
        send_text("1;\n", 1'b1);
        send_item(8'hFF, 1'b0);
        send_text("0x5\n", 1'b0);
    endtask

    // byte after the end is dropped, nul at line start ends the next body
    task automatic test_after_end();
        send_item("Z", 1'b0);
        send_item(CHAR_NUL, 1'b1);
    endtask

    task automatic test_size_overflow();
        send_text("1aB2cD3eF\n", 1'b1);
        send_item(8'h5A, 1'b0);
    endtask

    task automatic test_random_stream(input int target);
        int stop_at;
        int pick;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            pick = $urandom_range(9);
            if (pick < 8) begin
                send_random_body(1'b0);
            end else if (pick == 8) begin
                send_random_body(1'b1);
            end else begin
                repeat ($urandom_range(6, 1)) begin
                    send_item(8'($urandom_range(255)), $urandom_range(9) == 0);
                end
            end
        end
    endtask

    // receiver stalls long enough to back up the input, then the sender waits
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 200;
        send_random_body(1'b0);
        send_random_body(1'b0);
        wait_drained();
    endtask

    initial begin
        reset_decoder();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 11;
        rx_idle_pct = 87;
        test_crlf_chunk();
        test_extension_and_prefix();
        test_after_end();
        test_size_overflow();
        test_random_stream(280);

        tx_idle_pct = 87;
        rx_idle_pct = 11;
        test_random_stream(280);

        test_backpressure();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_stream(200);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
